// ===== sv/clock_date_field_editor_assert.svh =====
// Assertion macros for the clock date field editor.
// Used by the top-level RTL file, which checks its own logic; no other dependencies.
`ifndef CLOCK_DATE_FIELD_EDITOR_ASSERT_SVH
`define CLOCK_DATE_FIELD_EDITOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define CDFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cdfe assertion failed");

// Next-cycle implication, checked outside reset.
`define CDFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cdfe assertion failed");

`else

`define CDFE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CDFE_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/cdfe_pkg.sv =====
// Package for the clock date field editor: field codes, bounds, types
// and the stepping helpers. No dependencies.
`default_nettype none

package cdfe_pkg;

    localparam int YEAR_WIDTH_DEFAULT = 12;
    localparam int S_TDATA_W          = 48;
    localparam int M_TDATA_W          = 48;

    // Field codes, in editing order
    localparam logic [2:0] FIELD_HOUR   = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_SECOND = 3'd2;
    localparam logic [2:0] FIELD_YEAR   = 3'd3;
    localparam logic [2:0] FIELD_MONTH  = 3'd4;
    localparam logic [2:0] FIELD_DAY    = 3'd5;

    localparam logic [1:0] TURN_UP   = 2'd1;
    localparam logic [1:0] TURN_DOWN = 2'd2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EDIT = 1'b1;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MAX = 6'd59;
    localparam logic [3:0] MONTH_MIN  = 4'd1;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] DAY_MIN    = 5'd1;
    localparam logic [4:0] DAY_FEB    = 5'd28;
    localparam logic [4:0] DAY_SHORT  = 5'd30;
    localparam logic [4:0] DAY_LONG   = 5'd31;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    // Clock fields and edit cursor (year kept apart, its width is a parameter)
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] field;
    } cdfe_clock_t;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  turn;
        logic        accept_press;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [11:0] load_year;
    } cdfe_item_t;

    // Step up or down with wrap between lo and hi; other turn codes hold.
    function automatic logic [5:0] step_bounded(logic [5:0] v, logic [5:0] lo,
                                                logic [5:0] hi, logic [1:0] turn);
        logic [5:0] r;
        r = v;
        if (turn == TURN_UP) begin
            r = (v < hi) ? v + 6'd1 : lo;
        end else if (turn == TURN_DOWN) begin
            r = (v > lo) ? v - 6'd1 : hi;
        end
        return r;
    endfunction

    function automatic logic [4:0] day_limit(logic [3:0] m);
        logic [4:0] r;
        case (m)
            MONTH_FEB: r = DAY_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: r = DAY_SHORT;
            default: r = DAY_LONG;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cdfe_update.sv =====
// Next-state logic of the clock date field editor: load, step, advance.
// Depends on cdfe_pkg.
`default_nettype none

module cdfe_update #(
    parameter int YEAR_WIDTH = cdfe_pkg::YEAR_WIDTH_DEFAULT
) (
    input  wire cdfe_pkg::cdfe_clock_t cur_i,
    input  wire logic [YEAR_WIDTH-1:0] year_i,
    input  wire logic                  short_i,
    input  wire cdfe_pkg::cdfe_item_t  item_i,
    output cdfe_pkg::cdfe_clock_t      nxt_o,
    output logic [YEAR_WIDTH-1:0]      year_o,
    output logic                       finished_o
);

    logic [2:0] last_field;

    always_comb begin
        nxt_o      = cur_i;
        year_o     = year_i;
        finished_o = 1'b0;
        last_field = short_i ? cdfe_pkg::FIELD_SECOND : cdfe_pkg::FIELD_DAY;

        if (item_i.req_type == cdfe_pkg::REQ_LOAD) begin
            // copy all values, keep the cursor
            nxt_o.hour   = item_i.load_hour;
            nxt_o.minute = item_i.load_minute;
            nxt_o.second = item_i.load_second;
            nxt_o.day    = item_i.load_day;
            nxt_o.month  = item_i.load_month;
            year_o       = YEAR_WIDTH'(item_i.load_year);
        end else begin
            case (cur_i.field)
                cdfe_pkg::FIELD_HOUR: begin
                    nxt_o.hour = 5'(cdfe_pkg::step_bounded(6'(cur_i.hour), 6'd0,
                                    6'(cdfe_pkg::HOUR_MAX), item_i.turn));
                end
                cdfe_pkg::FIELD_MINUTE: begin
                    nxt_o.minute = cdfe_pkg::step_bounded(cur_i.minute, 6'd0,
                                    cdfe_pkg::MINSEC_MAX, item_i.turn);
                end
                cdfe_pkg::FIELD_SECOND: begin
                    nxt_o.second = cdfe_pkg::step_bounded(cur_i.second, 6'd0,
                                    cdfe_pkg::MINSEC_MAX, item_i.turn);
                end
                cdfe_pkg::FIELD_YEAR: begin
                    if (item_i.turn == cdfe_pkg::TURN_UP) begin
                        year_o = year_i + YEAR_WIDTH'(1);
                    end else if (item_i.turn == cdfe_pkg::TURN_DOWN) begin
                        year_o = year_i - YEAR_WIDTH'(1);
                    end
                end
                cdfe_pkg::FIELD_MONTH: begin
                    nxt_o.month = 4'(cdfe_pkg::step_bounded(6'(cur_i.month),
                                    6'(cdfe_pkg::MONTH_MIN), 6'(cdfe_pkg::MONTH_MAX),
                                    item_i.turn));
                end
                cdfe_pkg::FIELD_DAY: begin
                    nxt_o.day = 5'(cdfe_pkg::step_bounded(6'(cur_i.day),
                                    6'(cdfe_pkg::DAY_MIN),
                                    6'(cdfe_pkg::day_limit(cur_i.month)), item_i.turn));
                end
                default: begin
                end
            endcase

            // advance the cursor; past the last field go home and flag it
            if (item_i.accept_press) begin
                if (cur_i.field < last_field) begin
                    nxt_o.field = cur_i.field + 3'd1;
                end else begin
                    nxt_o.field = cdfe_pkg::FIELD_HOUR;
                    finished_o  = 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/clock_date_field_editor.sv =====
// Top level of the clock date field editor: input register, clock state,
// result register and config register. Depends on cdfe_pkg, cdfe_update.
//
// Usage:
//   s_ channel: one request item per handshake. s_tuser is the request kind
//   (0 load the date and time from s_tdata, 1 encoder event). m_ channel:
//   one result item per request carrying the full date and time, the field
//   under edit, and m_tlast high when the last field was just accepted.
//   cfg_ channel: one-bit short_sequence write (1 = hour, minute, second
//   only); write it only while no request is in flight. cfg_ready is
//   always high.
//   An accepted item passes through the input register and then the result
//   register before it is presented on m_.
//   Throughput: one item per cycle while m_tready is high, set by the combinational update between
//   the input register and the result register; the clock state register
//   feeds the next item directly, so back-to-back edits chain correctly.
//   Stall: when m_tready is low the result register holds, the input
//   register fills, then s_tready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous): both channels empty, time 00:00:00,
//   day 1, month 1, year 0, cursor on hour, short_sequence cleared.
`default_nettype none

module clock_date_field_editor #(
    parameter int YEAR_WIDTH = cdfe_pkg::YEAR_WIDTH_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // turn[1:0], accept_press[2], load_hour[7:3], load_minute[13:8],
    // load_second[19:14], load_day[24:20], load_month[28:25],
    // load_year[40:29], zero pad [47:41]
    input  wire logic [cdfe_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  wire logic                           s_tuser,
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // hour[4:0], minute[10:5], second[16:11], day[21:17], month[25:22],
    // year[37:26], selected_field[40:38], zero pad [47:41]
    output logic [cdfe_pkg::M_TDATA_W-1:0]      m_tdata,
    // finished
    output logic                                m_tlast,
    // configuration: short_sequence
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data
);

`include "clock_date_field_editor_assert.svh"

    // input register
    logic                  in_valid_reg, in_valid_next;
    cdfe_pkg::cdfe_item_t  in_item_reg, s_item;

    // architectural state
    cdfe_pkg::cdfe_clock_t cur_reg, cur_next;
    logic [YEAR_WIDTH-1:0] year_reg, year_next;
    logic                  short_reg;

    // result register
    logic                           m_valid_reg, m_valid_next;
    logic [cdfe_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                           m_last_reg, m_last_next;

    logic out_free, advance, s_fire, upd_finished;

    // unpack the input bus
    always_comb begin
        s_item.req_type     = s_tuser;
        s_item.turn         = s_tdata[1:0];
        s_item.accept_press = s_tdata[2];
        s_item.load_hour    = s_tdata[7:3];
        s_item.load_minute  = s_tdata[13:8];
        s_item.load_second  = s_tdata[19:14];
        s_item.load_day     = s_tdata[24:20];
        s_item.load_month   = s_tdata[28:25];
        s_item.load_year    = s_tdata[40:29];
    end

    // the result register frees when empty or being drained this cycle
    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    cdfe_update #(
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_update (
        .cur_i      (cur_reg),
        .year_i     (year_reg),
        .short_i    (short_reg),
        .item_i     (in_item_reg),
        .nxt_o      (cur_next),
        .year_o     (year_next),
        .finished_o (upd_finished)
    );

    always_comb begin
        in_valid_next = s_fire || (in_valid_reg && !advance);
        m_valid_next  = advance || (m_valid_reg && !m_tready);
        m_data_next   = {7'd0, cur_next.field, 12'(year_next), cur_next.month,
                         cur_next.day, cur_next.second, cur_next.minute, cur_next.hour};
        m_last_next   = upd_finished;
    end

    // control and clock state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            short_reg      <= 1'b0;
            cur_reg.hour   <= 5'd0;
            cur_reg.minute <= 6'd0;
            cur_reg.second <= 6'd0;
            cur_reg.day    <= cdfe_pkg::DAY_MIN;
            cur_reg.month  <= cdfe_pkg::MONTH_MIN;
            cur_reg.field  <= cdfe_pkg::FIELD_HOUR;
            year_reg       <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                short_reg <= cfg_data;
            end
            // commit the item's update as it moves into the result register
            if (advance) begin
                cur_reg  <= cur_next;
                year_reg <= year_next;
            end
        end
    end

    // payload: load on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
            m_last_reg <= m_last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // cursor never leaves the six fields
    `CDFE_ASSERT_IMP(a_field_range, aclk, aresetn, 1'b1, cur_reg.field <= cdfe_pkg::FIELD_DAY)
    // a finished result always shows the cursor back on hour
    `CDFE_ASSERT_IMP(a_last_home, aclk, aresetn, m_valid_reg && m_last_reg,
                     m_data_reg[40:38] == cdfe_pkg::FIELD_HOUR)
    // a blocked item stays in the input register
    `CDFE_ASSERT_NXT(a_stall_hold, aclk, aresetn, in_valid_reg && !out_free, in_valid_reg)
    // every item that advances produces a valid result
    `CDFE_ASSERT_NXT(a_result_follows, aclk, aresetn, advance, m_valid_reg)
    // full input register with a stalled output refuses new items
    `CDFE_ASSERT_IMP(a_backpressure, aclk, aresetn, in_valid_reg && m_valid_reg && !m_tready,
                     !s_tready)

endmodule

`default_nettype wire
